[design/cobs_crc8_frame_decoder_core_macros.svh]
// Assertion macros for the COBS / CRC-8 frame decoder checker.
// Each macro expands to one labeled concurrent assertion clocked on aclk.
`ifndef COBS_CRC8_FRAME_DECODER_CORE_MACROS_SVH
`define COBS_CRC8_FRAME_DECODER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCFD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCFD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that stays active through reset.
`define CCFD_ASSERT_NXT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ccfd_pkg.sv]
// Shared types, constants and the CRC-8 helper for the COBS / CRC-8 frame decoder.
// No dependencies; the front, queue, back and top files refer to it by scoped names.
`timescale 1ns / 1ps

package ccfd_pkg;

    // Payload bytes per frame, between the length byte and the CRC byte.
    localparam int PAYLOAD_BYTES = 16;

    // Decoded byte counter saturates at PAYLOAD_BYTES + 3.
    localparam int CNT_W = $clog2(PAYLOAD_BYTES + 4);
    // Index into one bank of the payload store.
    localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    // Frame queue between the front and back parts. Its depth matches the two
    // payload banks, so a good frame held in the queue always owns its own bank.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [7:0] CRC_POLY  = 8'h07;
    localparam logic [7:0] CRC_MSB   = 8'h80;
    localparam logic [7:0] CODE_FULL = 8'hFF;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_COBS  = 3'd1,
        ST_LEN   = 3'd2,
        ST_LBYTE = 3'd3,
        ST_CRC   = 3'd4
    } ccfd_status_t;

    // One finished frame, handed from the front to the back.
    typedef struct packed {
        ccfd_status_t status;
        logic         bank;
    } ccfd_entry_t;

    // Payload store write port driven by the front.
    typedef struct packed {
        logic             en;
        logic             bank;
        logic [IDX_W-1:0] addr;
        logic [7:0]       data;
    } ccfd_wr_t;

    // CRC-8, MSB first, over one byte.
    function automatic logic [7:0] ccfd_crc8(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((v & CRC_MSB) != 8'h00) begin
                v = (v << 1) ^ CRC_POLY;
            end else begin
                v = v << 1;
            end
        end
        return v;
    endfunction

endpackage

[design/ccfd_front.sv]
// Front part: accepts encoded bytes, undoes COBS, runs the CRC and length checks.
// Writes payload bytes into the store and queues one status entry per frame. Uses ccfd_pkg.
`timescale 1ns / 1ps

module ccfd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // in_byte[7:0]
    input  logic                  s_tlast,   // frame_end
    input  logic                  q_full,
    output logic                  q_push,
    output ccfd_pkg::ccfd_entry_t q_entry,
    output ccfd_pkg::ccfd_wr_t    wr
);

    logic [ccfd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]                 rem_reg, rem_next;
    logic                       full_reg, full_next;
    logic                       zp_reg, zp_next;
    logic [7:0]                 crc_reg, crc_next;
    logic [7:0]                 rcv_reg, rcv_next;
    logic                       lbad_reg, lbad_next;
    logic                       cerr_reg, cerr_next;
    logic                       bank_reg, bank_next;

    logic                       accept;
    logic                       take;
    logic [7:0]                 take_val;
    ccfd_pkg::ccfd_status_t     status;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // COBS decoding of one byte and update of the frame checks.
    always_comb begin
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        full_next = full_reg;
        zp_next   = zp_reg;
        crc_next  = crc_reg;
        rcv_next  = rcv_reg;
        lbad_next = lbad_reg;
        cerr_next = cerr_reg;
        take      = 1'b0;
        take_val  = 8'h00;
        wr.en     = 1'b0;
        wr.bank   = bank_reg;
        wr.addr   = '0;
        wr.data   = 8'h00;

        if (!cerr_reg) begin
            if (rem_reg == 8'h00) begin
                // Code byte: opens a block and emits the zero owed from the previous one, if any.
                if (s_tdata == 8'h00) begin
                    cerr_next = 1'b1;
                end else begin
                    take      = zp_reg;
                    rem_next  = s_tdata - 8'd1;
                    full_next = (s_tdata == ccfd_pkg::CODE_FULL);
                    zp_next   = (s_tdata == 8'd1);
                end
            end else begin
                take     = 1'b1;
                take_val = s_tdata;
                rem_next = rem_reg - 8'd1;
                if (rem_next == 8'h00) begin
                    zp_next = !full_reg;
                end
            end
        end

        // Place the decoded byte: length byte, payload, CRC byte, then ignored.
        if (take) begin
            if (cnt_reg == '0) begin
                lbad_next = (take_val != 8'(ccfd_pkg::PAYLOAD_BYTES));
                crc_next  = ccfd_pkg::ccfd_crc8(crc_reg, take_val);
            end else if (cnt_reg <= ccfd_pkg::CNT_W'(ccfd_pkg::PAYLOAD_BYTES)) begin
                wr.en    = accept;
                wr.addr  = ccfd_pkg::IDX_W'(cnt_reg - ccfd_pkg::CNT_W'(1));
                wr.data  = take_val;
                crc_next = ccfd_pkg::ccfd_crc8(crc_reg, take_val);
            end else if (cnt_reg == ccfd_pkg::CNT_W'(ccfd_pkg::PAYLOAD_BYTES + 1)) begin
                rcv_next = take_val;
            end
            if (cnt_reg < ccfd_pkg::CNT_W'(ccfd_pkg::PAYLOAD_BYTES + 3)) begin
                cnt_next = cnt_reg + ccfd_pkg::CNT_W'(1);
            end
        end
    end

    // Frame verdict from the state after this byte, highest priority first.
    always_comb begin
        priority if (cerr_next || rem_next != 8'h00) begin
            status = ccfd_pkg::ST_COBS;
        end else if (cnt_next != ccfd_pkg::CNT_W'(ccfd_pkg::PAYLOAD_BYTES + 2)) begin
            status = ccfd_pkg::ST_LEN;
        end else if (lbad_next) begin
            status = ccfd_pkg::ST_LBYTE;
        end else if (crc_next != rcv_next) begin
            status = ccfd_pkg::ST_CRC;
        end else begin
            status = ccfd_pkg::ST_OK;
        end
    end

    assign q_push         = accept && s_tlast;
    assign q_entry.status = status;
    assign q_entry.bank   = bank_reg;
    // A good frame keeps its bank for the drain; the next frame writes the other.
    assign bank_next      = (q_push && status == ccfd_pkg::ST_OK) ? !bank_reg : bank_reg;

    // Frame state registers, cleared after every frame end.
    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            cnt_reg  <= '0;
            rem_reg  <= 8'h00;
            full_reg <= 1'b0;
            zp_reg   <= 1'b0;
            crc_reg  <= 8'h00;
            rcv_reg  <= 8'h00;
            lbad_reg <= 1'b0;
            cerr_reg <= 1'b0;
        end else if (accept) begin
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            full_reg <= full_next;
            zp_reg   <= zp_next;
            crc_reg  <= crc_next;
            rcv_reg  <= rcv_next;
            lbad_reg <= lbad_next;
            cerr_reg <= cerr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_reg <= 1'b0;
        end else begin
            bank_reg <= bank_next;
        end
    end

endmodule

[design/ccfd_fifo.sv]
// Two-entry queue of finished frames between the front and back parts.
// Uses ccfd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ccfd_fifo (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  ccfd_pkg::ccfd_entry_t push_entry,
    input  logic                  pop,
    output ccfd_pkg::ccfd_entry_t head,
    output logic                  not_empty,
    output logic                  full
);

    ccfd_pkg::ccfd_entry_t        ent_reg [ccfd_pkg::QDEPTH];
    logic [ccfd_pkg::QPTR_W-1:0]  wp_reg, wp_next;
    logic [ccfd_pkg::QPTR_W-1:0]  rp_reg, rp_next;
    logic [ccfd_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;

    assign head      = ent_reg[rp_reg];
    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == ccfd_pkg::QCNT_W'(ccfd_pkg::QDEPTH));

    // Pointer and occupancy update.
    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wp_next = (wp_reg == ccfd_pkg::QPTR_W'(ccfd_pkg::QDEPTH - 1)) ? '0
                    : wp_reg + ccfd_pkg::QPTR_W'(1);
        end
        if (pop) begin
            rp_next = (rp_reg == ccfd_pkg::QPTR_W'(ccfd_pkg::QDEPTH - 1)) ? '0
                    : rp_reg + ccfd_pkg::QPTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + ccfd_pkg::QCNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - ccfd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wp_reg] <= push_entry;
        end
    end

endmodule

[design/ccfd_back.sv]
// Back part: holds the two-bank payload store and drains finished frames as results.
// Emits the inverted payload run or a single error result. Uses ccfd_pkg.
`timescale 1ns / 1ps

module ccfd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ccfd_pkg::ccfd_wr_t    wr,
    input  ccfd_pkg::ccfd_entry_t head,
    input  logic                  head_valid,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // out_byte[7:0]
    output logic [2:0]            m_tuser,   // status[2:0]
    output logic                  m_tlast    // end_of_run
);

    logic [7:0]                 mem [2][ccfd_pkg::PAYLOAD_BYTES];
    logic [7:0]                 q_reg;
    logic                       valid_reg, valid_next;
    logic [ccfd_pkg::IDX_W-1:0] idx_reg, idx_next;
    ccfd_pkg::ccfd_status_t     status_reg;
    logic                       err_reg;
    logic                       last_reg;

    logic                       load;
    logic                       is_err;
    logic                       run_end;

    // A new result enters the output register when it is empty or being taken.
    assign load    = head_valid && (!valid_reg || m_tready);
    assign is_err  = (head.status != ccfd_pkg::ST_OK);
    assign run_end = (idx_reg == ccfd_pkg::IDX_W'(ccfd_pkg::PAYLOAD_BYTES - 1));
    assign pop     = load && (is_err || run_end);

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            if (!is_err) begin
                idx_next = run_end ? '0 : idx_reg + ccfd_pkg::IDX_W'(1);
            end
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload store; the read register doubles as the output data register.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.bank][wr.addr] <= wr.data;
        end
        if (load && !is_err) begin
            q_reg <= mem[head.bank][idx_reg];
        end
    end

    // Result side fields.
    always_ff @(posedge aclk) begin
        if (load) begin
            status_reg <= head.status;
            err_reg    <= is_err;
            last_reg   <= is_err || run_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = err_reg ? 8'h00 : ~q_reg;
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule

[design/cobs_crc8_frame_decoder_core.sv]
// A frame's results pass through the frame queue and then the output register.
// Throughput: one encoded byte per cycle in, one result per cycle out while m_tready
// is high; a good frame drains PAYLOAD_BYTES results, a bad one gives one error result.
// Input stalls only while two finished frames wait, set by the two-entry frame queue
// and the two payload banks. Reset (aresetn low, synchronous) clears the frame state
// and the queue; the payload store is not cleared.
`timescale 1ns / 1ps

module cobs_crc8_frame_decoder_core (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // frame_end
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic [2:0] m_tuser,   // status[2:0]
    output logic       m_tlast    // end_of_run
);

    logic                  q_push;
    logic                  q_pop;
    logic                  q_full;
    logic                  q_not_empty;
    ccfd_pkg::ccfd_entry_t q_entry;
    ccfd_pkg::ccfd_entry_t q_head;
    ccfd_pkg::ccfd_wr_t    wr;

    // Byte intake and frame checks.
    ccfd_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_entry),
        .wr       (wr)
    );

    // Finished frames waiting for the drain.
    ccfd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .full       (q_full)
    );

    // Payload store and result drain.
    ccfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (wr),
        .head       (q_head),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

[design/ccfd_checker.sv]
// Port-level checker for the COBS / CRC-8 frame decoder, bound to the top level.
// Depends on cobs_crc8_frame_decoder_core_macros.svh for the assertion macros.
`timescale 1ns / 1ps
`include "cobs_crc8_frame_decoder_core_macros.svh"

module ccfd_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [2:0] m_tuser,
    input logic       m_tlast
);

    // A stalled result transaction holds its contents.
    `CCFD_ASSERT_NXT(a_m_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result changed while stalled")

    // An error result carries a zero byte and closes its run.
    `CCFD_ASSERT_IMP(a_err_form, m_tvalid && m_tuser != 3'd0, m_tdata == 8'h00 && m_tlast, "malformed error result")

    // Reset leaves no result pending.
    `CCFD_ASSERT_NXT_RST(a_rst_idle, !aresetn, !m_tvalid, "result valid after reset")

endmodule

bind cobs_crc8_frame_decoder_core ccfd_checker u_ccfd_checker (.*);
